// ===== rtl/core/dlbr_pkg.sv =====
// shared types, widths and constants for the dual lfsr bounded random unit
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package dlbr_pkg;

	localparam int LFSR_W  = 32;
	localparam int DRAW_W  = 16;
	localparam int UPPER_W = 17;
	localparam int CNT_W   = 5;

	localparam logic [LFSR_W-1:0] MASK_A     = 32'h29D1_E9EB;
	localparam logic [LFSR_W-1:0] MASK_B     = 32'h0F5C_DE95;
	localparam logic [LFSR_W-1:0] LFSR_INIT  = 32'h0000_0001;
	localparam logic [UPPER_W-1:0] DRAW_SPAN = 17'h1_0000;
	// the divider runs one step per dividend bit
	localparam logic [CNT_W-1:0] DIV_LAST    = 5'd16;

	// controller to datapath
	typedef struct packed {
		logic load_upper;
		logic div_step;
		logic lim_load;
		logic lfsr_step;
		logic div_start_draw;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bypass;
		logic div_last;
		logic draw_ok;
	} sts_t;

	// one right-shifting galois step
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] r,
			input logic [LFSR_W-1:0] mask);
		logic [LFSR_W-1:0] s;
		s = r >> 1;
		if (r[0]) begin
			s = s ^ mask;
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/dlbr_ctrl.sv =====
// sequencing fsm: bound setup, draw/reject loop, reduction, output hand-off
// depends on dlbr_pkg
`timescale 1ns / 1ps

module dlbr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  dlbr_pkg::sts_t sts,
	output dlbr_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LIM  = 3'd1;
	localparam logic [2:0] ST_DRAW = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_upper = 1'b1;
					state_d        = ST_LIM;
				end
			end
			ST_LIM: begin
				if (sts.bypass) begin
					state_d = ST_DRAW;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) begin
						cmd.lim_load = 1'b1;
						state_d      = ST_DRAW;
					end
				end
			end
			ST_DRAW: begin
				cmd.lfsr_step = 1'b1;
				if (sts.bypass) begin
					state_d = ST_DONE;
				end else if (sts.draw_ok) begin
					cmd.div_start_draw = 1'b1;
					state_d            = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/dlbr_dp.sv =====
// datapath: the two lfsrs, bound and limit registers, radix-2 remainder unit,
// output register; depends on dlbr_pkg
`timescale 1ns / 1ps

module dlbr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dlbr_pkg::LFSR_W-1:0]         cfg_wdata,
	input  logic [dlbr_pkg::UPPER_W-1:0]        upper,
	input  dlbr_pkg::cmd_t                      cmd,
	output dlbr_pkg::sts_t                      sts,
	output logic [dlbr_pkg::DRAW_W-1:0]         value
);

	logic [dlbr_pkg::LFSR_W-1:0]  lfsr_a_q;
	logic [dlbr_pkg::LFSR_W-1:0]  lfsr_b_q;
	logic [dlbr_pkg::LFSR_W-1:0]  lfsr_a_nxt;
	logic [dlbr_pkg::LFSR_W-1:0]  lfsr_b_nxt;
	logic [dlbr_pkg::DRAW_W-1:0]  draw_nxt;
	logic [dlbr_pkg::DRAW_W-1:0]  draw_q;
	logic [dlbr_pkg::UPPER_W-1:0] upper_q;
	logic [dlbr_pkg::UPPER_W-1:0] limit_q;
	logic [dlbr_pkg::UPPER_W-1:0] dvd_q;
	logic [dlbr_pkg::DRAW_W-1:0]  rem_q;
	logic [dlbr_pkg::UPPER_W-1:0] rem_sh;
	logic [dlbr_pkg::UPPER_W-1:0] divisor;
	logic [dlbr_pkg::UPPER_W-1:0] rem_nxt;
	logic [dlbr_pkg::CNT_W-1:0]   cnt_q;
	logic [dlbr_pkg::DRAW_W-1:0]  value_q;

	assign lfsr_a_nxt = dlbr_pkg::lfsr_next(lfsr_a_q, dlbr_pkg::MASK_A);
	assign lfsr_b_nxt = dlbr_pkg::lfsr_next(lfsr_b_q, dlbr_pkg::MASK_B);
	assign draw_nxt   = lfsr_a_nxt[dlbr_pkg::DRAW_W-1:0] ^ lfsr_b_nxt[dlbr_pkg::DRAW_W-1:0];

	// restoring remainder step, one dividend bit per cycle
	assign divisor = {1'b0, upper_q[dlbr_pkg::DRAW_W-1:0]};
	assign rem_sh  = {rem_q, dvd_q[dlbr_pkg::UPPER_W-1]};
	assign rem_nxt = (rem_sh >= divisor) ? (rem_sh - divisor) : rem_sh;

	assign sts.bypass   = (upper_q == '0) || upper_q[dlbr_pkg::UPPER_W-1];
	assign sts.div_last = (cnt_q == dlbr_pkg::DIV_LAST);
	assign sts.draw_ok  = ({1'b0, draw_nxt} < limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_a_q <= dlbr_pkg::LFSR_INIT;
			lfsr_b_q <= dlbr_pkg::LFSR_INIT;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				lfsr_a_q <= cfg_wdata;
				lfsr_b_q <= dlbr_pkg::LFSR_INIT;
			end else if (cmd.lfsr_step) begin
				lfsr_a_q <= lfsr_a_nxt;
				lfsr_b_q <= lfsr_b_nxt;
			end
			if (cmd.load_upper || cmd.div_start_draw) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_upper) begin
			upper_q <= upper;
		end
		if (cmd.lfsr_step) begin
			draw_q <= draw_nxt;
		end
		if (cmd.load_upper) begin
			dvd_q <= dlbr_pkg::DRAW_SPAN;
			rem_q <= '0;
		end else if (cmd.div_start_draw) begin
			dvd_q <= {1'b0, draw_nxt};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt[dlbr_pkg::DRAW_W-1:0];
		end
		// largest multiple of upper not above the draw span
		if (cmd.lim_load) begin
			limit_q <= dlbr_pkg::DRAW_SPAN - {1'b0, rem_nxt[dlbr_pkg::DRAW_W-1:0]};
		end
		if (cmd.out_load) begin
			value_q <= sts.bypass ? draw_q : rem_q;
		end
	end

	assign value = value_q;

endmodule

// ===== rtl/core/dual_lfsr_bounded_random_unit.sv =====
// the time from input transaction to result valid is set by two 17-step radix-2 remainder
// passes and the draw/reject loop; an upper of zero or of 65536 and above skips both passes
// and takes a single draw; a new request is taken only once the fsm is back in idle, and a
// finished result waits in the fsm while the previous one is still unaccepted
// reset: both lfsrs load 1 as if seed 1 were written, fsm idle, no result pending
// top level of the dual lfsr bounded random unit; depends on dlbr_pkg, dlbr_ctrl, dlbr_dp
`timescale 1ns / 1ps

module dual_lfsr_bounded_random_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// seed write port, reloads both lfsrs
	input  logic                         cfg_we,
	input  logic [dlbr_pkg::LFSR_W-1:0]  cfg_wdata,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dlbr_pkg::UPPER_W-1:0] upper,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dlbr_pkg::DRAW_W-1:0]  value
);

	// command and status between the fsm and the datapath
	dlbr_pkg::cmd_t cmd;
	dlbr_pkg::sts_t sts;

	// fsm: idle -> limit pass (65536 mod upper) -> draw loop, one draw a cycle,
	// retried while the draw falls at or above the limit -> remainder pass ->
	// hand-off into the output register, which frees the fsm; an out-of-range upper skips both passes
	dlbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: lfsr pair, shared remainder unit, limit and output registers
	dlbr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.upper     (upper),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value)
	);

	// an accepted transaction moves the fsm out of idle, so in_ready does not stay high
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one still in work");

	// the output register is only overwritten once its content was taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// neither the remainder unit nor the lfsr pair steps while a request may be accepted
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.lfsr_step) |-> !in_ready)
		else $error("datapath active while idle");

endmodule

// ===== bench/dlbr_checker.sv =====
// result checker for the dual lfsr bounded random unit: keeps its own copy of both lfsrs,
// predicts each bounded draw and compares it with the result channel; depends on dlbr_pkg
`timescale 1ns / 1ps

module dlbr_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dlbr_pkg::LFSR_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [dlbr_pkg::UPPER_W-1:0] upper,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [dlbr_pkg::DRAW_W-1:0]  value,
	output int unsigned                  fail_cnt,
	output int unsigned                  pending_cnt,
	output int unsigned                  checked_cnt
);
	import dlbr_pkg::*;

	typedef struct {
		int unsigned         seq;
		logic [DRAW_W-1:0]   value;
	} draw_exp_t;

	draw_exp_t          draw_exp_q[$];
	logic [LFSR_W-1:0]  gen_a;
	logic [LFSR_W-1:0]  gen_b;
	int unsigned        req_seq;

	function automatic logic [LFSR_W-1:0] galois_shift(input logic [LFSR_W-1:0] r,
			input logic [LFSR_W-1:0] taps);
		return r[0] ? ((r >> 1) ^ taps) : (r >> 1);
	endfunction

	task automatic draw_raw(output logic [DRAW_W-1:0] d);
		gen_a = galois_shift(gen_a, MASK_A);
		gen_b = galois_shift(gen_b, MASK_B);
		d = gen_a[DRAW_W-1:0] ^ gen_b[DRAW_W-1:0];
	endtask

	// rejection sampling: redraw until below the largest multiple of the bound
	task automatic predict_bounded_draw(input logic [UPPER_W-1:0] bound,
			output logic [DRAW_W-1:0] v);
		logic [DRAW_W-1:0] d;
		int unsigned       ceiling;
		if (bound == '0 || bound >= DRAW_SPAN) begin
			draw_raw(d);
			v = d;
		end else begin
			ceiling = (int'(DRAW_SPAN) / int'(bound)) * int'(bound);
			do begin
				draw_raw(d);
			end while (int'(d) >= ceiling);
			v = DRAW_W'(int'(d) % int'(bound));
		end
	endtask

	task automatic report_mismatch(input string msg);
		fail_cnt++;
		if (fail_cnt <= 20) begin
			$display("%0t ns mismatch: %s", $realtime, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		draw_exp_t         e;
		logic [DRAW_W-1:0] v;
		if (!arst_n) begin
			gen_a = LFSR_INIT;
			gen_b = LFSR_INIT;
			draw_exp_q.delete();
			req_seq = 0;
			fail_cnt = 0;
			checked_cnt = 0;
			pending_cnt <= 0;
		end else begin
			if (cfg_we) begin
				gen_a = cfg_wdata;
				gen_b = LFSR_INIT;
			end
			if (in_valid && in_ready) begin
				predict_bounded_draw(upper, v);
				e.seq = req_seq;
				e.value = v;
				draw_exp_q.push_back(e);
				req_seq++;
			end
			if (out_valid && out_ready) begin
				if (draw_exp_q.size() == 0) begin
					report_mismatch($sformatf("value %0d with no request outstanding", value));
				end else begin
					e = draw_exp_q.pop_front();
					checked_cnt++;
					if (value !== e.value) begin
						report_mismatch($sformatf("request %0d value expected %0d got %0d",
							e.seq, e.value, value));
					end
				end
			end
			pending_cnt <= draw_exp_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// top level bench for the dual lfsr bounded random unit: clock, reset, seed writes,
// request stimulus, result back-pressure and the verdict; depends on dlbr_pkg and dlbr_checker
`timescale 1ns / 1ps

module tb_top;
	import dlbr_pkg::*;

	// cycles with no transaction on either channel before the run is declared hung
	localparam int WDOG_LIMIT = 3000;
	// quiet period at the end, once every result has already come back
	localparam int TAIL_CYCLES = 64;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LFSR_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [UPPER_W-1:0]  upper = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DRAW_W-1:0]   value;

	int unsigned         fail_cnt;
	int unsigned         pending_cnt;
	int unsigned         checked_cnt;
	int unsigned         sent_cnt = 0;
	int unsigned         quiet_cycles = 0;
	// idle percentages for the two sides, changed between phases
	int unsigned         tx_idle_pct = 0;
	int unsigned         rx_idle_pct = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	dual_lfsr_bounded_random_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.upper     (upper),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	dlbr_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.upper       (upper),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.fail_cnt    (fail_cnt),
		.pending_cnt (pending_cnt),
		.checked_cnt (checked_cnt)
	);

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// hang detection: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					WDOG_LIMIT, pending_cnt);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// present one bound and hold it until the transaction completes; valid is left high so
	// back-to-back requests need no extra assignment in the same step
	task automatic send_request(input logic [UPPER_W-1:0] bound);
		int unsigned gap;
		gap = 0;
		while (gap < 24 && $urandom_range(0, 99) < tx_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		upper <= bound;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sent_cnt++;
	endtask

	// stop sending and wait until every predicted value has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) begin
			@(posedge clk);
		end
	endtask

	// only called with the unit idle and the request channel quiet
	task automatic write_seed(input logic [LFSR_W-1:0] s);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// bound mix: small bounds, full range, the rejection-heavy upper half, powers of two,
	// exactly 65536, and the out-of-range zero and above-65536 values
	function automatic logic [UPPER_W-1:0] pick_bound();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			return UPPER_W'($urandom_range(1, 256));
		end else if (sel < 58) begin
			return UPPER_W'($urandom_range(1, 65536));
		end else if (sel < 74) begin
			return UPPER_W'($urandom_range(32769, 65535));
		end else if (sel < 84) begin
			return UPPER_W'(1 << $urandom_range(0, 16));
		end else if (sel < 91) begin
			return DRAW_SPAN;
		end else if (sel < 95) begin
			return '0;
		end
		return UPPER_W'($urandom_range(65537, 131071));
	endfunction

	task automatic run_random(input int unsigned n);
		repeat (n) send_request(pick_bound());
	endtask

	initial begin
		logic [UPPER_W-1:0] corner_bounds [20];
		corner_bounds = '{
			17'd1, 17'd2, 17'd3, 17'd7, 17'd255, 17'd256, 17'd21845, 17'h0AAAA,
			17'd32768, 17'd32769, 17'd40000, 17'd65535, 17'h1_0000, 17'h1_0001,
			17'h1_5555, 17'h1_FFFF, 17'd0, 17'd30000, 17'd100, 17'd1
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// sender idles lightly, receiver heavily
		tx_idle_pct = 27;
		rx_idle_pct = 61;

		// reset seed: bound extremes, tight and loose rejection, out-of-range bounds
		foreach (corner_bounds[i]) begin
			send_request(corner_bounds[i]);
		end
		drain_results();

		// zero seed leaves the first lfsr stuck at zero
		write_seed('0);
		run_random(40);
		drain_results();

		write_seed('1);
		run_random(220);
		drain_results();

		// swap the idle pressure between the two sides
		tx_idle_pct = 61;
		rx_idle_pct = 27;
		write_seed(LFSR_W'($urandom()));
		run_random(230);
		drain_results();

		// full rate both ways, with one pause in the middle that empties the pipeline
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_seed(LFSR_INIT);
		run_random(120);
		drain_results();
		run_random(120);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d requests, %0d results compared, over reset, zero, all-ones,",
			sent_cnt, checked_cnt);
		$display("random and unit seeds with bounds from 0 to 131071 and varied idling");
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
